// ===== sv/bcpg_pkg.sv =====
package bcpg_pkg;

    localparam int COORD_W = 32;
    localparam int RAD_W   = COORD_W - 1;
    localparam int MAG_W   = COORD_W + 1;
    localparam int PROD_W  = 2 * MAG_W;
    localparam int APB_DW  = 32;
    localparam int APB_AW  = 4;

    localparam logic [RAD_W-1:0] RAD_MAX = '1;

    localparam logic [1:0] REG_INIT_CX  = 2'd0;
    localparam logic [1:0] REG_INIT_CY  = 2'd1;
    localparam logic [1:0] REG_INIT_RAD = 2'd2;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic                      restart;
    } bcpg_in_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] center_x;
        logic signed [COORD_W-1:0] center_y;
        logic        [RAD_W-1:0]   radius;
        logic                      grew;
    } bcpg_out_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIFF,
        S_SQ_GO,
        S_SQ_WAIT,
        S_CMP,
        S_TEST,
        S_RT_GO,
        S_RT_WAIT,
        S_K_CALC,
        S_K_GO,
        S_K_WAIT,
        S_DV_GO,
        S_DV_WAIT,
        S_UPD,
        S_OUT
    } bcpg_state_t;

endpackage

// ===== sv/bounding_circle_point_grow_unit.sv =====
// Channel   Ports                        Direction  Moves
// input     s_valid s_ready s_data       in         point_x, point_y, restart
// result    m_valid m_ready m_data       out        center_x, center_y, radius, grew
// config    psel penable pwrite paddr..  in/out     init_center_x/y, init_radius
//
// A point inside the circle needs only the 33-step bit-serial squaring.
// A point outside needs squaring, a 33-step root, a 33-step multiply by the
// radius growth and a 66-step restoring divide per axis.
// One point is in flight at a time; the next is taken once the result is in the
// output register, which holds it until m_ready.
// Synchronous active-low reset clears the circle and the init registers to zero.
module bounding_circle_point_grow_unit
    import bcpg_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  bcpg_in_t          s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output bcpg_out_t         m_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    bcpg_state_t state_reg, state_next;

    logic signed [COORD_W-1:0] init_cx_reg, init_cy_reg;
    logic        [RAD_W-1:0]   init_rad_reg;
    logic signed [COORD_W-1:0] cx_reg, cy_reg;
    logic        [RAD_W-1:0]   rad_reg;
    logic signed [COORD_W-1:0] px_reg, py_reg;
    logic        [MAG_W-1:0]   ax_reg, ay_reg;
    logic                      sx_reg, sy_reg;
    logic        [PROD_W-1:0]  dist2_reg, rr_reg;
    logic        [MAG_W-1:0]   d_reg, nr_reg;
    logic                      grew_reg;
    logic                      m_valid_reg;
    bcpg_out_t                 m_data_reg;

    logic                      cfg_wr;
    logic        [1:0]         cfg_idx;
    logic                      s_fire, out_load;
    logic                      mul_start, mul2_start, rt_start, dv_start;
    logic        [MAG_W-1:0]   k, mul0_a, mul1_a, rad_ext;
    logic        [MAG_W:0]     dx, dy, nr_sum;
    logic        [MAG_W:0]     delta_x, delta_y;
    logic        [COORD_W+1:0] cx_sum, cy_sum;
    logic                      mul0_done, mul1_done, mul2_done;
    logic        [PROD_W-1:0]  prod0, prod1, prod2;
    logic                      rt_done, rt_inexact;
    logic        [MAG_W-1:0]   rt_root;
    logic                      dv0_done, dv1_done;
    logic        [PROD_W-1:0]  quot0, quot1;

    // configuration port
    assign pready  = 1'b1;
    assign cfg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_comb begin
        unique case (cfg_idx)
            REG_INIT_CX:  prdata = init_cx_reg;
            REG_INIT_CY:  prdata = init_cy_reg;
            REG_INIT_RAD: prdata = {1'b0, init_rad_reg};
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            init_cx_reg  <= '0;
            init_cy_reg  <= '0;
            init_rad_reg <= '0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_INIT_CX:  init_cx_reg  <= pwdata[COORD_W-1:0];
                REG_INIT_CY:  init_cy_reg  <= pwdata[COORD_W-1:0];
                REG_INIT_RAD: init_rad_reg <= pwdata[RAD_W-1:0];
                default:      ;
            endcase
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:    if (s_valid) state_next = S_DIFF;
            S_DIFF:    state_next = S_SQ_GO;
            S_SQ_GO:   state_next = S_SQ_WAIT;
            S_SQ_WAIT: if (mul0_done) state_next = S_CMP;
            S_CMP:     state_next = S_TEST;
            S_TEST:    state_next = (dist2_reg > rr_reg) ? S_RT_GO : S_OUT;
            S_RT_GO:   state_next = S_RT_WAIT;
            S_RT_WAIT: if (rt_done) state_next = S_K_CALC;
            S_K_CALC:  state_next = S_K_GO;
            S_K_GO:    state_next = S_K_WAIT;
            S_K_WAIT:  if (mul0_done) state_next = S_DV_GO;
            S_DV_GO:   state_next = S_DV_WAIT;
            S_DV_WAIT: if (dv0_done) state_next = S_UPD;
            S_UPD:     state_next = S_OUT;
            S_OUT:     if (!m_valid_reg || m_ready) state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        s_ready    = (state_reg == S_IDLE);
        mul_start  = (state_reg == S_SQ_GO) || (state_reg == S_K_GO);
        mul2_start = (state_reg == S_SQ_GO);
        rt_start   = (state_reg == S_RT_GO);
        dv_start   = (state_reg == S_DV_GO);
        out_load   = (state_reg == S_OUT) && (!m_valid_reg || m_ready);
    end

    assign s_fire = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // datapath
    always_comb begin
        dx      = {{2{px_reg[COORD_W-1]}}, px_reg} - {{2{cx_reg[COORD_W-1]}}, cx_reg};
        dy      = {{2{py_reg[COORD_W-1]}}, py_reg} - {{2{cy_reg[COORD_W-1]}}, cy_reg};
        rad_ext = {2'b00, rad_reg};
        k       = nr_reg - rad_ext;
        mul0_a  = (state_reg == S_K_GO) ? k : ax_reg;
        mul1_a  = (state_reg == S_K_GO) ? k : ay_reg;
        nr_sum  = {1'b0, rad_ext} + {1'b0, d_reg} + (MAG_W+1)'(1);
        // move is bounded by the offset, so it fits in MAG_W bits
        delta_x = sx_reg ? -{1'b0, quot0[MAG_W-1:0]} : {1'b0, quot0[MAG_W-1:0]};
        delta_y = sy_reg ? -{1'b0, quot1[MAG_W-1:0]} : {1'b0, quot1[MAG_W-1:0]};
        cx_sum  = {{2{cx_reg[COORD_W-1]}}, cx_reg} + delta_x;
        cy_sum  = {{2{cy_reg[COORD_W-1]}}, cy_reg} + delta_y;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cx_reg   <= '0;
            cy_reg   <= '0;
            rad_reg  <= '0;
            grew_reg <= 1'b0;
        end else begin
            if (s_fire) begin
                grew_reg <= 1'b0;
                if (s_data.restart) begin
                    cx_reg  <= init_cx_reg;
                    cy_reg  <= init_cy_reg;
                    rad_reg <= init_rad_reg;
                end
            end
            if (state_reg == S_UPD) begin
                cx_reg   <= cx_sum[COORD_W-1:0];
                cy_reg   <= cy_sum[COORD_W-1:0];
                rad_reg  <= (nr_reg > {2'b00, RAD_MAX}) ? RAD_MAX : nr_reg[RAD_W-1:0];
                grew_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            px_reg <= s_data.point_x;
            py_reg <= s_data.point_y;
        end
        if (state_reg == S_DIFF) begin
            sx_reg <= dx[MAG_W];
            sy_reg <= dy[MAG_W];
            ax_reg <= dx[MAG_W] ? MAG_W'(-dx) : dx[MAG_W-1:0];
            ay_reg <= dy[MAG_W] ? MAG_W'(-dy) : dy[MAG_W-1:0];
        end
        if (state_reg == S_CMP) begin
            dist2_reg <= prod0 + prod1;
            rr_reg    <= prod2;
        end
        if ((state_reg == S_RT_WAIT) && rt_done) begin
            d_reg <= rt_root + MAG_W'(rt_inexact);
        end
        if (state_reg == S_K_CALC) begin
            nr_reg <= nr_sum[MAG_W:1];
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg.center_x <= cx_reg;
            m_data_reg.center_y <= cy_reg;
            m_data_reg.radius   <= rad_reg;
            m_data_reg.grew     <= grew_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    bcpg_mul #(.OP_W(MAG_W)) u_mul0 (
        .aclk(aclk), .aresetn(aresetn), .start(mul_start),
        .a(mul0_a), .b(ax_reg), .done(mul0_done), .prod(prod0)
    );

    bcpg_mul #(.OP_W(MAG_W)) u_mul1 (
        .aclk(aclk), .aresetn(aresetn), .start(mul_start),
        .a(mul1_a), .b(ay_reg), .done(mul1_done), .prod(prod1)
    );

    bcpg_mul #(.OP_W(MAG_W)) u_mul2 (
        .aclk(aclk), .aresetn(aresetn), .start(mul2_start),
        .a(rad_ext), .b(rad_ext), .done(mul2_done), .prod(prod2)
    );

    bcpg_sqrt #(.ROOT_W(MAG_W)) u_sqrt (
        .aclk(aclk), .aresetn(aresetn), .start(rt_start),
        .radicand(dist2_reg), .done(rt_done), .root(rt_root), .inexact(rt_inexact)
    );

    bcpg_div #(.NUM_W(PROD_W), .DEN_W(MAG_W)) u_div0 (
        .aclk(aclk), .aresetn(aresetn), .start(dv_start),
        .num(prod0), .den(d_reg), .done(dv0_done), .quot(quot0)
    );

    bcpg_div #(.NUM_W(PROD_W), .DEN_W(MAG_W)) u_div1 (
        .aclk(aclk), .aresetn(aresetn), .start(dv_start),
        .num(prod1), .den(d_reg), .done(dv1_done), .quot(quot1)
    );

    a_mul_lockstep: assert property (@(posedge aclk) disable iff (!aresetn)
        mul0_done == mul1_done)
        else $error("multipliers out of step");

    a_sq_lockstep: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SQ_WAIT) |-> (mul0_done == mul2_done))
        else $error("radius square out of step");

    a_div_lockstep: assert property (@(posedge aclk) disable iff (!aresetn)
        dv0_done == dv1_done)
        else $error("dividers out of step");

    a_grow_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_UPD) |-> (nr_reg > rad_ext))
        else $error("new radius not larger than old");

    a_accept_next: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> (state_reg == S_DIFF))
        else $error("accepted point not started");

endmodule

// ===== sv/bcpg_mul.sv =====
module bcpg_mul
    import bcpg_pkg::*;
#(
    parameter int OP_W = MAG_W
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [OP_W-1:0]     a,
    input  logic [OP_W-1:0]     b,
    output logic                done,
    output logic [2*OP_W-1:0]   prod
);

    localparam int CNT_W = $clog2(OP_W + 1);

    logic [OP_W-1:0]   mcand_reg;
    logic [2*OP_W-1:0] prod_reg, prod_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [OP_W:0]     sum;
    logic              last;

    // shift-add: multiplier bits leave the low half as product bits enter the top
    always_comb begin
        sum  = {1'b0, prod_reg[2*OP_W-1:OP_W]} + (prod_reg[0] ? {1'b0, mcand_reg} : '0);
        last = (cnt_reg == CNT_W'(OP_W - 1));
    end

    always_comb begin
        prod_next = prod_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            prod_next = {{OP_W{1'b0}}, b};
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            prod_next = {sum, prod_reg[OP_W-1:1]};
            cnt_next  = cnt_reg + 1'b1;
            if (last) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            mcand_reg <= a;
        end
        prod_reg <= prod_next;
    end

    assign done = done_reg;
    assign prod = prod_reg;

endmodule

// ===== sv/bcpg_sqrt.sv =====
module bcpg_sqrt
    import bcpg_pkg::*;
#(
    parameter int ROOT_W = MAG_W
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [2*ROOT_W-1:0] radicand,
    output logic                done,
    output logic [ROOT_W-1:0]   root,
    output logic                inexact
);

    localparam int CNT_W = $clog2(ROOT_W + 1);

    logic [2*ROOT_W-1:0] rad_reg, rad_next;
    logic [ROOT_W+1:0]   rem_reg, rem_next;
    logic [ROOT_W-1:0]   root_reg, root_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [ROOT_W+3:0]   rem_sh, trial, diff;
    logic                ge;

    // one root bit per cycle, two radicand bits consumed
    always_comb begin
        rem_sh = {rem_reg, rad_reg[2*ROOT_W-1:2*ROOT_W-2]};
        trial  = {2'b00, root_reg, 2'b01};
        ge     = (rem_sh >= trial);
        diff   = rem_sh - trial;
    end

    always_comb begin
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rad_next  = {rad_reg[2*ROOT_W-3:0], 2'b00};
            rem_next  = ge ? diff[ROOT_W+1:0] : rem_sh[ROOT_W+1:0];
            root_next = {root_reg[ROOT_W-2:0], ge};
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(ROOT_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done    = done_reg;
    assign root    = root_reg;
    assign inexact = (rem_reg != '0);

endmodule

// ===== sv/bcpg_div.sv =====
module bcpg_div
    import bcpg_pkg::*;
#(
    parameter int NUM_W = PROD_W,
    parameter int DEN_W = MAG_W
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [NUM_W-1:0]  num,
    input  logic [DEN_W-1:0]  den,
    output logic              done,
    output logic [NUM_W-1:0]  quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] num_reg, num_next;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DEN_W:0]   rs, dif;
    logic             ge;

    // restoring division; quotient bits shift in where numerator bits leave
    always_comb begin
        rs  = {rem_reg, num_reg[NUM_W-1]};
        ge  = (rs >= {1'b0, den_reg});
        dif = rs - {1'b0, den_reg};
    end

    always_comb begin
        num_next  = num_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            num_next  = num;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            num_next = {num_reg[NUM_W-2:0], ge};
            rem_next = ge ? dif[DEN_W-1:0] : rs[DEN_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(NUM_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            den_reg <= den;
        end
        num_reg <= num_next;
        rem_reg <= rem_next;
    end

    assign done = done_reg;
    assign quot = num_reg;

endmodule

// ===== sim/bounding_circle_point_grow_unit_tb.sv =====
`timescale 1ns / 100ps

module bounding_circle_point_grow_unit_tb;
    import bcpg_pkg::*;

    localparam int LIMIT_CYCLES = 3000000;
    localparam int DRAIN_CYCLES = 300;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    bcpg_in_t          s_data = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    bcpg_out_t         m_data;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    bounding_circle_point_grow_unit u_top (.*);

    always #5 aclk = ~aclk;

    // predictor copy of the circle and the init registers
    logic signed [COORD_W-1:0] cfg_cx = '0, cfg_cy = '0;
    logic        [RAD_W-1:0]   cfg_rad = '0;
    logic signed [COORD_W-1:0] circ_x = '0, circ_y = '0;
    logic        [RAD_W-1:0]   circ_rad = '0;

    bcpg_out_t circle_q[$];
    int        errors = 0;
    int        cycles = 0;
    int        burst_left = 0;
    logic      hold_req = 1'b0;
    int        hold_cnt = 0;

    function automatic bcpg_out_t grow_circle(bcpg_in_t p);
        logic signed [33:0] dx, dy;
        logic [32:0] ax, ay;
        logic [67:0] dist2, rad2;
        logic [33:0] d, t;
        logic [34:0] nr, k;
        logic [69:0] mx, my;
        bcpg_out_t o;
        if (p.restart) begin
            circ_x = cfg_cx;
            circ_y = cfg_cy;
            circ_rad = cfg_rad;
        end
        dx = {{2{p.point_x[31]}}, p.point_x} - {{2{circ_x[31]}}, circ_x};
        dy = {{2{p.point_y[31]}}, p.point_y} - {{2{circ_y[31]}}, circ_y};
        ax = dx[33] ? 33'(-dx) : dx[32:0];
        ay = dy[33] ? 33'(-dy) : dy[32:0];
        dist2 = 68'(ax) * 68'(ax) + 68'(ay) * 68'(ay);
        rad2 = 68'(circ_rad) * 68'(circ_rad);
        o.grew = 1'b0;
        if (dist2 > rad2) begin
            d = '0;
            for (int b = 32; b >= 0; b--) begin
                t = d | (34'd1 << b);
                if (68'(t) * 68'(t) <= dist2) d = t;
            end
            if (68'(d) * 68'(d) != dist2) d = d + 1;
            nr = (35'(circ_rad) + 35'(d) + 35'd1) >> 1;
            k = nr - 35'(circ_rad);
            mx = (70'(k) * 70'(ax)) / 70'(d);
            my = (70'(k) * 70'(ay)) / 70'(d);
            circ_x = dx[33] ? circ_x - mx[31:0] : circ_x + mx[31:0];
            circ_y = dy[33] ? circ_y - my[31:0] : circ_y + my[31:0];
            circ_rad = (nr > 35'(RAD_MAX)) ? RAD_MAX : nr[RAD_W-1:0];
            o.grew = 1'b1;
        end
        o.center_x = circ_x;
        o.center_y = circ_y;
        o.radius = circ_rad;
        return o;
    endfunction

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= APB_AW'({idx, 2'b00});
        pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_INIT_CX:  cfg_cx = val;
            REG_INIT_CY:  cfg_cy = val;
            REG_INIT_RAD: cfg_rad = val[RAD_W-1:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    // one transaction; valid stays up across a burst
    task automatic send_point(input bcpg_in_t p, input logic chk, input bcpg_out_t typed);
        bcpg_out_t e;
        int gap;
        s_valid <= 1'b1;
        s_data <= p;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        e = grow_circle(p);
        circle_q.push_back(chk ? typed : e);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 12);
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (circle_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [31:0] pick_coord(logic [31:0] base);
        case ($urandom_range(0, 7))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2, 3: return $urandom();
            default: return base + (32'($signed($urandom()) >>> $urandom_range(4, 31)));
        endcase
    endfunction

    // receiver: random stall pattern plus one long hold-off on request
    always @(posedge aclk) begin
        if (hold_req && hold_cnt < 3000) begin
            hold_cnt <= hold_cnt + 1;
            m_ready <= 1'b0;
        end else if (cycles[9:8] == 2'b11) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge aclk) begin
        bcpg_out_t e;
        if (aresetn && m_valid && m_ready) begin
            if (circle_q.size() == 0) begin
                $display("%0t: unexpected result %h", $time, m_data);
                errors++;
            end else begin
                e = circle_q.pop_front();
                if (m_data.center_x !== e.center_x) begin
                    $display("%0t: center_x exp %h got %h", $time, e.center_x, m_data.center_x);
                    errors++;
                end
                if (m_data.center_y !== e.center_y) begin
                    $display("%0t: center_y exp %h got %h", $time, e.center_y, m_data.center_y);
                    errors++;
                end
                if (m_data.radius !== e.radius) begin
                    $display("%0t: radius exp %h got %h", $time, e.radius, m_data.radius);
                    errors++;
                end
                if (m_data.grew !== e.grew) begin
                    $display("%0t: grew exp %b got %b", $time, e.grew, m_data.grew);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("Some tests failed");
            $finish;
        end
    end

    typedef struct {
        bcpg_in_t  pt;
        logic      chk;
        bcpg_out_t typed;
    } stim_row_t;

    stim_row_t dir_tab[] = '{
        '{'{32'sd0, 32'sd0, 1'b0}, 1'b1, '{32'sd0, 32'sd0, 31'd0, 1'b0}},
        '{'{32'sd65536, 32'sd0, 1'b0}, 1'b1, '{32'sd32768, 32'sd0, 31'd32768, 1'b1}},
        '{'{32'sd32768, 32'sd0, 1'b0}, 1'b0, '0},
        '{'{32'sd0, 32'sd0, 1'b1}, 1'b1, '{32'sd0, 32'sd0, 31'd0, 1'b0}},
        '{'{32'sh7fffffff, 32'sh7fffffff, 1'b0}, 1'b0, '0},
        '{'{32'sh80000000, 32'sh80000000, 1'b0}, 1'b0, '0},
        '{'{32'sh7fffffff, 32'sh80000000, 1'b0}, 1'b0, '0},
        '{'{32'sh80000000, 32'sh7fffffff, 1'b1}, 1'b0, '0},
        '{'{32'sh7fffffff, 32'sh80000000, 1'b0}, 1'b0, '0},
        '{'{32'sh80000000, 32'sh80000000, 1'b0}, 1'b0, '0},
        '{'{32'sh7fffffff, 32'sh7fffffff, 1'b0}, 1'b0, '0},
        '{'{32'sd0, 32'sd0, 1'b0}, 1'b0, '0},
        '{'{-32'sd1, -32'sd1, 1'b1}, 1'b0, '0},
        '{'{32'sd1, 32'sd1, 1'b0}, 1'b0, '0},
        '{'{32'sd3, -32'sd4, 1'b0}, 1'b0, '0},
        '{'{-32'sd3, 32'sd4, 1'b0}, 1'b0, '0}
    };

    initial begin
        bcpg_in_t p;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_tab[i]) send_point(dir_tab[i].pt, dir_tab[i].chk, dir_tab[i].typed);
        wait_idle();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    reg_write(REG_INIT_CX, 32'h80000000);
                    reg_write(REG_INIT_CY, 32'h7fffffff);
                    reg_write(REG_INIT_RAD, 32'hffffffff);
                end
                1: begin
                    reg_write(REG_INIT_CX, 32'h7fffffff);
                    reg_write(REG_INIT_CY, 32'h80000000);
                    reg_write(REG_INIT_RAD, 32'h80000000);
                end
                2: begin
                    reg_write(REG_INIT_CX, $urandom());
                    reg_write(REG_INIT_CY, $urandom());
                    reg_write(REG_INIT_RAD, $urandom() >> $urandom_range(0, 31));
                end
                default: begin
                    reg_write(REG_INIT_CX, 32'h0);
                    reg_write(REG_INIT_CY, 32'h0);
                    reg_write(REG_INIT_RAD, 32'h0);
                end
            endcase
            for (int n = 0; n < 200; n++) begin
                if (ph == 1 && n == 40) hold_req <= 1'b1;
                p.restart = (n == 0) || ($urandom_range(0, 15) == 0);
                p.point_x = pick_coord(p.restart ? cfg_cx : circ_x);
                p.point_y = pick_coord(p.restart ? cfg_cy : circ_y);
                send_point(p, 1'b0, '0);
            end
            wait_idle();
        end

        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
